FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Depends on nothing; the user supplies i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A plain condition that must be true at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    `ASSERT_PROP(label, (cond), msg)

`endif

FILE: rtl/gpms_pkg.sv
// Package for the grid path maximum block: sizes, types and helpers.
// Used by the interfaces, the cell unit, the output queue and the top level; depends on nothing.
package gpms_pkg;

    localparam int MAX_COLS   = 512;
    localparam int MAX_ROWS   = 512;
    localparam int MAX_SKIPS  = 2;
    localparam int NUM_COUNTS = MAX_SKIPS + 1;

    localparam int DIM_W = 10;
    localparam int VAL_W = 16;
    localparam int SUM_W = 32;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IDX_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int POS_W = ((IDX_MAX_W > DIM_W) ? IDX_MAX_W : DIM_W) + 2;

    localparam int LINE_W = NUM_COUNTS * SUM_W;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [LINE_W-1:0] t_line;

    localparam t_sum UNREACHED = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic first;
        logic top_ok;
        logic left_ok;
    } t_cell_ctrl;

    function automatic logic [POS_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [POS_W-1:0] r;
        r = POS_W'(v);
        if (v == '0) begin
            r = POS_W'(1);
        end else if (r > POS_W'(hi)) begin
            r = POS_W'(hi);
        end
        return r;
    endfunction

endpackage

FILE: rtl/gpms_if.sv
// Valid/ready channel interfaces for the grid path maximum block.
// Depends on gpms_pkg for the payload types.
interface gpms_in_if;
    logic                   valid;
    logic                   ready;
    gpms_pkg::t_value       cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gpms_out_if;
    logic                   valid;
    logic                   ready;
    gpms_pkg::t_sum         best_amount;

    modport source (output valid, output best_amount, input ready);
    modport sink   (input valid, input best_amount, output ready);
endinterface

FILE: rtl/gpms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module gpms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gpms_cell_unit.sv
// Per-cell update: best sums for each skip count from the top and left
// neighbors, and the best over all counts. Depends on gpms_pkg.
module gpms_cell_unit (
    input  gpms_pkg::t_cell_ctrl i_ctrl,
    input  gpms_pkg::t_value     i_value,
    input  gpms_pkg::t_line      i_top,
    input  gpms_pkg::t_line      i_left,
    output gpms_pkg::t_line      o_fresh,
    output gpms_pkg::t_sum       o_best
);

    gpms_pkg::t_sum top_v   [gpms_pkg::NUM_COUNTS];
    gpms_pkg::t_sum left_v  [gpms_pkg::NUM_COUNTS];
    gpms_pkg::t_sum prior   [gpms_pkg::NUM_COUNTS];
    gpms_pkg::t_sum fresh   [gpms_pkg::NUM_COUNTS];
    gpms_pkg::t_sum value_x;
    gpms_pkg::t_sum best;

    always_comb begin
        value_x = gpms_pkg::t_sum'(i_value);
        for (int k = 0; k < gpms_pkg::NUM_COUNTS; k++) begin
            top_v[k]  = i_ctrl.top_ok ? i_top[k*gpms_pkg::SUM_W +: gpms_pkg::SUM_W]
                                      : gpms_pkg::UNREACHED;
            left_v[k] = i_ctrl.left_ok ? i_left[k*gpms_pkg::SUM_W +: gpms_pkg::SUM_W]
                                       : gpms_pkg::UNREACHED;
            if (i_ctrl.first) begin
                prior[k] = (k == 0) ? '0 : gpms_pkg::UNREACHED;
            end else begin
                prior[k] = (top_v[k] > left_v[k]) ? top_v[k] : left_v[k];
            end
        end
        for (int k = 0; k < gpms_pkg::NUM_COUNTS; k++) begin
            fresh[k] = (prior[k] != gpms_pkg::UNREACHED) ? prior[k] + value_x
                                                        : gpms_pkg::UNREACHED;
            if (k > 0) begin
                if (value_x < 0 && prior[k-1] != gpms_pkg::UNREACHED
                        && prior[k-1] > fresh[k]) begin
                    fresh[k] = prior[k-1];
                end
            end
            o_fresh[k*gpms_pkg::SUM_W +: gpms_pkg::SUM_W] = fresh[k];
        end
        best = fresh[0];
        for (int k = 1; k < gpms_pkg::NUM_COUNTS; k++) begin
            if (fresh[k] > best) begin
                best = fresh[k];
            end
        end
        o_best = best;
    end

endmodule

FILE: rtl/gpms_out_buf.sv
// Two-entry result queue in front of the output channel.
// Depends on gpms_pkg and the gpms_out_if interface.
module gpms_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpms_pkg::t_sum    i_data,
    input  logic              i_pend,
    output logic              o_can_take,
    gpms_out_if.source        o_res
);

    gpms_pkg::t_sum r_data [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           pop;
    logic [2:0]     after;

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.best_amount = r_data[r_rp];
    assign pop               = o_res.valid && o_res.ready;

    // The result of the cell now in the update stage, plus one more from
    // a cell accepted now, must both fit.
    assign after      = 3'(r_cnt) - 3'(pop) + 3'(i_pend);
    assign o_can_take = (after <= 3'd1);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/grid_path_max_with_skips.sv
// The block takes one grid cell per cycle in row-major order while it is not
// holding cells off. In the cycle after it accepts the last cell of a grid,
// it queues the best right/down path sum with up to MAX_SKIPS (two) skipped
// negative cells. A cell is read from the row buffer in the cycle it is
// accepted and updated and written back in the next, so the rate is one cell
// per cycle, set by the read-modify-write of the row buffer; a one-column grid
// is served at full rate through a bypass of the line just written. Cells are
// held off only while the result queue could not take one more result. No
// clearing pass follows reset. Up to two results are held for the output side.
module grid_path_max_with_skips (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gpms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gpms_pkg::DIM_W-1:0]          i_cfg_data,
    gpms_in_if.sink                             i_cell,
    gpms_out_if.source                          o_best
);

    logic [gpms_pkg::DIM_W-1:0]  r_num_rows;
    logic [gpms_pkg::DIM_W-1:0]  r_num_cols;
    logic [gpms_pkg::ROW_W-1:0]  r_row, n_row;
    logic [gpms_pkg::COL_W-1:0]  r_col, n_col;

    logic [gpms_pkg::POS_W-1:0]  rows_eff, cols_eff, cur_r, cur_c;
    logic                        is_last;
    logic                        row_wrap;
    logic                        accept;
    logic                        can_take;
    gpms_pkg::t_cell_ctrl        cur_ctrl;

    logic                        r_s2_valid;
    logic                        r_s2_last;
    gpms_pkg::t_cell_ctrl        r_s2_ctrl;
    logic [gpms_pkg::COL_W-1:0]  r_s2_col;
    gpms_pkg::t_value            r_s2_val;

    gpms_pkg::t_line             ram_rdata;
    gpms_pkg::t_line             top_line;
    gpms_pkg::t_line             fresh;
    gpms_pkg::t_line             r_left;
    gpms_pkg::t_line             r_byp_data;
    logic                        r_byp;
    gpms_pkg::t_sum              best;

    assign rows_eff = gpms_pkg::clamp_dim(r_num_rows, gpms_pkg::MAX_ROWS);
    assign cols_eff = gpms_pkg::clamp_dim(r_num_cols, gpms_pkg::MAX_COLS);

    always_comb begin
        cur_c = gpms_pkg::POS_W'(r_col);
        cur_r = gpms_pkg::POS_W'(r_row);
        row_wrap = 1'b0;
        if (cur_c >= cols_eff) begin
            cur_c = '0;
            cur_r = cur_r + gpms_pkg::POS_W'(1);
        end
        if (cur_r >= rows_eff) begin
            cur_r = '0;
            row_wrap = 1'b1;
        end
        is_last = (cur_r == rows_eff - gpms_pkg::POS_W'(1))
               && (cur_c == cols_eff - gpms_pkg::POS_W'(1));
        if (is_last) begin
            n_col = '0;
            n_row = '0;
        end else if (cur_c + gpms_pkg::POS_W'(1) >= cols_eff) begin
            n_col = '0;
            n_row = cur_r[gpms_pkg::ROW_W-1:0] + gpms_pkg::ROW_W'(1);
        end else begin
            n_col = cur_c[gpms_pkg::COL_W-1:0] + gpms_pkg::COL_W'(1);
            n_row = cur_r[gpms_pkg::ROW_W-1:0];
        end
        cur_ctrl.first   = (cur_r == '0) && (cur_c == '0);
        cur_ctrl.top_ok  = (cur_r != '0);
        cur_ctrl.left_ok = (cur_c != '0) && !row_wrap;
    end

    assign i_cell.ready = can_take;
    assign accept       = i_cell.valid && i_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= gpms_pkg::DIM_W'(1);
            r_num_cols <= gpms_pkg::DIM_W'(1);
            r_row      <= '0;
            r_col      <= '0;
            r_s2_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (gpms_pkg::t_cfg_idx'(i_cfg_idx))
                    gpms_pkg::CFG_NUM_ROWS: begin
                        r_num_rows <= i_cfg_data;
                    end
                    gpms_pkg::CFG_NUM_COLS: begin
                        r_num_cols <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_s2_valid <= accept;
            r_byp      <= r_s2_valid && accept
                       && (r_s2_col == cur_c[gpms_pkg::COL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_last <= is_last;
            r_s2_ctrl <= cur_ctrl;
            r_s2_col  <= cur_c[gpms_pkg::COL_W-1:0];
            r_s2_val  <= i_cell.cell_value;
        end
        if (r_s2_valid) begin
            r_left     <= fresh;
            r_byp_data <= fresh;
        end
    end

    gpms_ram #(
        .WIDTH (gpms_pkg::LINE_W),
        .DEPTH (gpms_pkg::MAX_COLS)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_col),
        .i_wdata (fresh),
        .i_raddr (cur_c[gpms_pkg::COL_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign top_line = r_byp ? r_byp_data : ram_rdata;

    gpms_cell_unit u_cell (
        .i_ctrl  (r_s2_ctrl),
        .i_value (r_s2_val),
        .i_top   (top_line),
        .i_left  (r_left),
        .o_fresh (fresh),
        .o_best  (best)
    );

    gpms_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_s2_valid && r_s2_last),
        .i_data     (best),
        .i_pend     (r_s2_valid && r_s2_last),
        .o_can_take (can_take),
        .o_res      (o_best)
    );

endmodule

FILE: rtl/gpms_checker.sv
// Port-level checks for the grid path maximum block, bound to its top level.
// Depends on assert_macros.svh and the top level's channel ports.
`include "assert_macros.svh"

module gpms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);

    `ASSERT_PROP(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result request dropped")
    `ASSERT_PROP(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result changed while stalled")
    `ASSERT_PROP(a_out_cause, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "result without a cell two cycles earlier")
    `ASSERT_ALWAYS(a_stall_cause, i_in_ready || i_out_valid, "input stalled with no result pending")

endmodule

bind grid_path_max_with_skips gpms_checker u_gpms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_best.valid),
    .i_out_ready (o_best.ready),
    .i_out_data  (o_best.best_amount)
);
